/* src/cpt_pkg.sv */
// Shared types and constants for the circle pair time-to-impact block.
`timescale 1ns / 1ps

package cpt_pkg;

    // Default store depth in circles
    localparam int MAX_CIRCLES_DEF = 64;

    // Width of one stored circle: pos_x, pos_y, vel_x, vel_y, radius
    localparam int ENTRY_W = 4 * 32 + 31;

    // Operand width of the shared multiplier (signed)
    localparam int OPW = 68;
    // Product magnitude width
    localparam int PRW = 2 * OPW;
    // Divider numerator, remainder and step counter widths
    localparam int DNW = 84;
    localparam int DRW = 69;
    localparam int DCW = 7;

    // Saturation limits of the result time
    localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDJ,
        ST_RDI,
        ST_DIFF,
        ST_MSET,
        ST_MUL,
        ST_MEND,
        ST_SQRT,
        ST_DSET,
        ST_DIV,
        ST_FIN,
        ST_NEXT,
        ST_EMIT
    } t_state;

    // Products taken per pair, in order
    typedef enum logic [3:0] {
        M_PXVX,
        M_PYVY,
        M_VXVX,
        M_VYVY,
        M_PXPX,
        M_PYPY,
        M_RR,
        M_BB,
        M_AD
    } t_mstep;

endpackage

/* src/cpt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/circle_pair_time_to_impact.sv */
// Top level: circle loader and pairwise time-to-impact sequencer.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | to block  | i_in_valid / o_in_stall   | i_pos_x i_pos_y i_vel_x i_vel_y
//          |           |                           | i_radius i_last
//  out     | from block| o_out_valid / i_out_stall | o_impact_time o_found
//
// A circle item is taken in any cycle in which o_in_stall is low. An item with last starts
// the pair walk, during which o_in_stall is high. Each pair takes store reads and then the
// shared shift-add multiplier (one cycle per multiplier bit, nine products), a square root
// and a division; a pair that is not approaching leaves after its second product. Reset
// is synchronous, active low, and empties the store. The result waits in an output
// register; circles keep loading while it is stalled, and only the next walk's end waits
// for it to be taken.
`timescale 1ns / 1ps

module circle_pair_time_to_impact #(
    parameter int MAX_CIRCLES = cpt_pkg::MAX_CIRCLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic [30:0]        i_radius,
    input  logic               i_last,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_impact_time,
    output logic               o_found
);

    localparam int CW  = $clog2(MAX_CIRCLES + 1);
    localparam int AW  = $clog2(MAX_CIRCLES);
    localparam int ENW = cpt_pkg::ENTRY_W;
    localparam int OPW = cpt_pkg::OPW;
    localparam int PRW = cpt_pkg::PRW;
    localparam int DNW = cpt_pkg::DNW;
    localparam int DRW = cpt_pkg::DRW;
    localparam int DCW = cpt_pkg::DCW;

    cpt_pkg::t_state r_state, n_state;
    cpt_pkg::t_mstep r_mstep, n_mstep;

    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_i, n_i;

    logic [ENW-1:0] r_cj, n_cj;
    logic signed [32:0] r_dpx, n_dpx, r_dpy, n_dpy, r_dvx, n_dvx, r_dvy, n_dvy;
    logic [31:0] r_rr, n_rr;
    logic signed [OPW-1:0] r_b, n_b, r_a, n_a, r_d, n_d;
    logic signed [PRW:0] r_t, n_t;

    logic [PRW-1:0] r_acc, n_acc, r_ma, n_ma, r_sbit, n_sbit;
    logic [OPW-1:0] r_mb, n_mb;
    logic r_mneg, n_mneg;

    logic r_nneg, n_nneg;
    logic [DNW-1:0] r_dn, n_dn, r_dq, n_dq;
    logic [DRW-1:0] r_dr, n_dr;
    logic [DCW-1:0] r_dcnt, n_dcnt;

    logic signed [31:0] r_best, n_best;
    logic r_found, n_found;
    logic r_ovalid, n_ovalid;
    logic signed [31:0] r_otime, n_otime;
    logic r_ofound, n_ofound;

    // Store port
    logic           ram_we;
    logic [AW-1:0]  ram_raddr;
    logic [ENW-1:0] ram_rdata;

    logic in_acc, out_free, room;
    logic [CW-1:0] cnt_inc;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;
    assign room     = r_cnt < CW'(MAX_CIRCLES);
    assign cnt_inc  = room ? r_cnt + CW'(1) : r_cnt;

    cpt_ram #(
        .WIDTH (ENW),
        .DEPTH (MAX_CIRCLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata ({i_pos_x, i_pos_y, i_vel_x, i_vel_y, i_radius}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Multiplier operand select
    logic signed [OPW-1:0] op_a, op_b;
    logic [OPW-1:0] mag_a, mag_b;
    logic signed [PRW:0] prod;

    always_comb begin
        unique case (r_mstep)
            cpt_pkg::M_PXVX: begin
                op_a = OPW'(r_dpx); op_b = OPW'(r_dvx);
            end
            cpt_pkg::M_PYVY: begin
                op_a = OPW'(r_dpy); op_b = OPW'(r_dvy);
            end
            cpt_pkg::M_VXVX: begin
                op_a = OPW'(r_dvx); op_b = OPW'(r_dvx);
            end
            cpt_pkg::M_VYVY: begin
                op_a = OPW'(r_dvy); op_b = OPW'(r_dvy);
            end
            cpt_pkg::M_PXPX: begin
                op_a = OPW'(r_dpx); op_b = OPW'(r_dpx);
            end
            cpt_pkg::M_PYPY: begin
                op_a = OPW'(r_dpy); op_b = OPW'(r_dpy);
            end
            cpt_pkg::M_RR: begin
                op_a = $signed({{(OPW-32){1'b0}}, r_rr});
                op_b = $signed({{(OPW-32){1'b0}}, r_rr});
            end
            cpt_pkg::M_BB: begin
                op_a = r_b; op_b = r_b;
            end
            cpt_pkg::M_AD: begin
                op_a = r_a; op_b = r_d;
            end
            default: begin
                op_a = '0; op_b = '0;
            end
        endcase
        mag_a = op_a[OPW-1] ? OPW'(-op_a) : OPW'(op_a);
        mag_b = op_b[OPW-1] ? OPW'(-op_b) : OPW'(op_b);
        prod  = r_mneg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});
    end

    // Next state
    logic signed [OPW-1:0] sum_b;
    logic signed [PRW:0]   disc;
    logic                  walk_more_i, walk_more_j;

    assign sum_b       = r_b + prod[OPW-1:0];
    assign disc        = r_t - prod;
    assign walk_more_i = (r_i + CW'(1)) < r_cnt;
    assign walk_more_j = (r_j + CW'(2)) < r_cnt;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cpt_pkg::ST_IDLE: begin
                if (in_acc && i_last) begin
                    n_state = (cnt_inc < CW'(2)) ? cpt_pkg::ST_EMIT : cpt_pkg::ST_RDJ;
                end
            end
            cpt_pkg::ST_RDJ:  n_state = cpt_pkg::ST_RDI;
            cpt_pkg::ST_RDI:  n_state = cpt_pkg::ST_DIFF;
            cpt_pkg::ST_DIFF: n_state = cpt_pkg::ST_MSET;
            cpt_pkg::ST_MSET: n_state = cpt_pkg::ST_MUL;
            cpt_pkg::ST_MUL: begin
                if (r_mb == '0) n_state = cpt_pkg::ST_MEND;
            end
            cpt_pkg::ST_MEND: begin
                n_state = cpt_pkg::ST_MSET;
                if (r_mstep == cpt_pkg::M_PYVY && (sum_b[OPW-1] || sum_b == '0)) begin
                    n_state = cpt_pkg::ST_NEXT;
                end else if (r_mstep == cpt_pkg::M_AD) begin
                    n_state = disc[PRW] ? cpt_pkg::ST_NEXT : cpt_pkg::ST_SQRT;
                end
            end
            cpt_pkg::ST_SQRT: begin
                if (r_sbit == '0) n_state = cpt_pkg::ST_DSET;
            end
            cpt_pkg::ST_DSET: n_state = cpt_pkg::ST_DIV;
            cpt_pkg::ST_DIV: begin
                if (r_dcnt == '0) n_state = cpt_pkg::ST_FIN;
            end
            cpt_pkg::ST_FIN:  n_state = cpt_pkg::ST_NEXT;
            cpt_pkg::ST_NEXT: begin
                n_state = (walk_more_i || walk_more_j) ? cpt_pkg::ST_RDJ : cpt_pkg::ST_EMIT;
            end
            cpt_pkg::ST_EMIT: begin
                if (out_free) n_state = cpt_pkg::ST_IDLE;
            end
            default: n_state = cpt_pkg::ST_IDLE;
        endcase
    end

    // Handshake and store control
    always_comb begin
        o_in_stall = (r_state != cpt_pkg::ST_IDLE);
        ram_we     = (r_state == cpt_pkg::ST_IDLE) && i_in_valid && room;
        ram_raddr  = (r_state == cpt_pkg::ST_RDJ) ? r_j[AW-1:0] : r_i[AW-1:0];
    end

    // Datapath next values
    logic [PRW-1:0]    sq_try;
    logic [DRW-1:0]    dv_try, a_ext;
    logic signed [OPW:0] bs_diff;
    logic [OPW:0]      bs_mag;
    logic [DNW:0]      q_adj;
    logic [31:0]       t_mag;
    logic signed [31:0] t_val;

    always_comb begin
        n_cnt = r_cnt; n_j = r_j; n_i = r_i; n_mstep = r_mstep;
        n_cj = r_cj;
        n_dpx = r_dpx; n_dpy = r_dpy; n_dvx = r_dvx; n_dvy = r_dvy; n_rr = r_rr;
        n_b = r_b; n_a = r_a; n_d = r_d; n_t = r_t;
        n_acc = r_acc; n_ma = r_ma; n_mb = r_mb; n_mneg = r_mneg; n_sbit = r_sbit;
        n_nneg = r_nneg; n_dn = r_dn; n_dq = r_dq; n_dr = r_dr; n_dcnt = r_dcnt;
        n_best = r_best; n_found = r_found;
        n_ovalid = r_ovalid && i_out_stall;
        n_otime = r_otime; n_ofound = r_ofound;

        sq_try  = r_ma + r_sbit;
        a_ext   = {1'b0, r_a};
        dv_try  = {r_dr[DRW-2:0], r_dn[DNW-1]};
        bs_diff = $signed({r_b[OPW-1], r_b}) - $signed({1'b0, r_ma[OPW-1:0]});
        bs_mag  = bs_diff[OPW] ? (OPW+1)'(-bs_diff) : (OPW+1)'(bs_diff);
        q_adj   = {1'b0, r_dq} + (DNW+1)'(r_nneg && (r_dr != '0));
        t_mag   = {1'b0, q_adj[30:0]};
        if (q_adj[DNW:31] != '0) begin
            t_val = r_nneg ? cpt_pkg::T_MIN : cpt_pkg::T_MAX;
        end else begin
            t_val = r_nneg ? $signed(~t_mag + 32'd1) : $signed(t_mag);
        end

        unique case (r_state)
            cpt_pkg::ST_IDLE: begin
                // Load a circle, start the walk on last
                if (in_acc) begin
                    n_cnt = cnt_inc;
                    n_j   = '0;
                    n_i   = CW'(1);
                end
            end
            cpt_pkg::ST_RDJ: begin
            end
            cpt_pkg::ST_RDI: begin
                n_cj = ram_rdata;
            end
            cpt_pkg::ST_DIFF: begin
                // Relative position, relative velocity, contact distance
                n_dpx = $signed({ram_rdata[158], ram_rdata[158:127]})
                      - $signed({r_cj[158], r_cj[158:127]});
                n_dpy = $signed({ram_rdata[126], ram_rdata[126:95]})
                      - $signed({r_cj[126], r_cj[126:95]});
                n_dvx = $signed({r_cj[94], r_cj[94:63]})
                      - $signed({ram_rdata[94], ram_rdata[94:63]});
                n_dvy = $signed({r_cj[62], r_cj[62:31]})
                      - $signed({ram_rdata[62], ram_rdata[62:31]});
                n_rr  = {1'b0, r_cj[30:0]} + {1'b0, ram_rdata[30:0]};
                n_mstep = cpt_pkg::M_PXVX;
            end
            cpt_pkg::ST_MSET: begin
                n_ma   = {{(PRW-OPW){1'b0}}, mag_a};
                n_mb   = mag_b;
                n_mneg = op_a[OPW-1] ^ op_b[OPW-1];
                n_acc  = '0;
            end
            cpt_pkg::ST_MUL: begin
                // Shift-add one multiplier bit
                if (r_mb != '0) begin
                    n_acc = r_mb[0] ? r_acc + r_ma : r_acc;
                    n_ma  = r_ma << 1;
                    n_mb  = r_mb >> 1;
                end
            end
            cpt_pkg::ST_MEND: begin
                unique case (r_mstep)
                    cpt_pkg::M_PXVX: n_b = prod[OPW-1:0];
                    cpt_pkg::M_PYVY: n_b = sum_b;
                    cpt_pkg::M_VXVX: n_a = prod[OPW-1:0];
                    cpt_pkg::M_VYVY: n_a = r_a + prod[OPW-1:0];
                    cpt_pkg::M_PXPX: n_d = prod[OPW-1:0];
                    cpt_pkg::M_PYPY: n_d = r_d + prod[OPW-1:0];
                    cpt_pkg::M_RR:   n_d = r_d - prod[OPW-1:0];
                    cpt_pkg::M_BB:   n_t = prod;
                    cpt_pkg::M_AD: begin
                        n_acc  = disc[PRW-1:0];
                        n_ma   = '0;
                        n_sbit = {2'b01, {(PRW-2){1'b0}}};
                    end
                    default: ;
                endcase
                if (r_mstep != cpt_pkg::M_AD) begin
                    n_mstep = cpt_pkg::t_mstep'(r_mstep + 4'd1);
                end
            end
            cpt_pkg::ST_SQRT: begin
                // One root bit per cycle
                if (r_sbit != '0) begin
                    if (r_acc >= sq_try) begin
                        n_acc = r_acc - sq_try;
                        n_ma  = (r_ma >> 1) + r_sbit;
                    end else begin
                        n_ma  = r_ma >> 1;
                    end
                    n_sbit = r_sbit >> 2;
                end
            end
            cpt_pkg::ST_DSET: begin
                n_nneg = bs_diff[OPW];
                n_dn   = {bs_mag[OPW-1:0], 16'd0};
                n_dq   = '0;
                n_dr   = '0;
                n_dcnt = DCW'(DNW);
            end
            cpt_pkg::ST_DIV: begin
                // Restoring division, one quotient bit per cycle
                if (r_dcnt != '0) begin
                    if (dv_try >= a_ext) begin
                        n_dr = dv_try - a_ext;
                        n_dq = {r_dq[DNW-2:0], 1'b1};
                    end else begin
                        n_dr = dv_try;
                        n_dq = {r_dq[DNW-2:0], 1'b0};
                    end
                    n_dn   = r_dn << 1;
                    n_dcnt = r_dcnt - DCW'(1);
                end
            end
            cpt_pkg::ST_FIN: begin
                n_found = 1'b1;
                if (t_val < r_best) n_best = t_val;
            end
            cpt_pkg::ST_NEXT: begin
                // Advance to the next pair
                if (walk_more_i) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_j = r_j + CW'(1);
                    n_i = r_j + CW'(2);
                end
            end
            cpt_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_otime  = r_found ? r_best : cpt_pkg::T_MAX;
                    n_ofound = r_found;
                    n_cnt    = '0;
                    n_best   = cpt_pkg::T_MAX;
                    n_found  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cpt_pkg::ST_IDLE;
            r_mstep  <= cpt_pkg::M_PXVX;
            r_cnt    <= '0;
            r_j      <= '0;
            r_i      <= '0;
            r_best   <= cpt_pkg::T_MAX;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
            r_dcnt   <= '0;
            r_sbit   <= '0;
            r_mb     <= '0;
        end else begin
            r_state  <= n_state;
            r_mstep  <= n_mstep;
            r_cnt    <= n_cnt;
            r_j      <= n_j;
            r_i      <= n_i;
            r_best   <= n_best;
            r_found  <= n_found;
            r_ovalid <= n_ovalid;
            r_dcnt   <= n_dcnt;
            r_sbit   <= n_sbit;
            r_mb     <= n_mb;
        end
        r_cj   <= n_cj;
        r_dpx  <= n_dpx;
        r_dpy  <= n_dpy;
        r_dvx  <= n_dvx;
        r_dvy  <= n_dvy;
        r_rr   <= n_rr;
        r_b    <= n_b;
        r_a    <= n_a;
        r_d    <= n_d;
        r_t    <= n_t;
        r_acc  <= n_acc;
        r_ma   <= n_ma;
        r_mneg <= n_mneg;
        r_nneg <= n_nneg;
        r_dn   <= n_dn;
        r_dq   <= n_dq;
        r_dr   <= n_dr;
        r_otime  <= n_otime;
        r_ofound <= n_ofound;
    end

    assign o_out_valid   = r_ovalid;
    assign o_impact_time = r_otime;
    assign o_found       = r_ofound;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_CIRCLES))
        else $error("circle count exceeds store depth");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpt_pkg::ST_RDJ) |-> (r_j < r_i) && (r_i < r_cnt))
        else $error("pair indices out of order");

    a_mul_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpt_pkg::ST_MUL && r_mb != '0) |=> (r_state == cpt_pkg::ST_MUL))
        else $error("multiplier left with bits pending");

    a_fin_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpt_pkg::ST_FIN) |=> r_found)
        else $error("candidate time not recorded");

    a_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_ofound) |-> (r_otime == cpt_pkg::T_MAX))
        else $error("no-impact result without sentinel time");
`endif

endmodule
